// ===== rtl/min_heap_timer_queue_core_defines.svh =====
// Assertion macros shared by the timer queue checker.
// Depends on nothing; the including file supplies clock and reset by name.
`ifndef MIN_HEAP_TIMER_QUEUE_CORE_DEFINES_SVH
`define MIN_HEAP_TIMER_QUEUE_CORE_DEFINES_SVH
// Same-cycle implication, sampled on the rising edge, quiet during reset.
`define MHTQ_ASSERT_NOW(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define MHTQ_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) else $error(msg);
`endif

// ===== rtl/mhtq_pkg.sv =====
// Shared types, codes and sizes of the timer queue.
// Depends on nothing; the engine, the top level and the checker refer to it by scoped names.
package mhtq_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] expire_time;
      logic [15:0] handle;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        popped_valid;
      logic [15:0] handle_out;
      logic        callback_due;
      logic [5:0]  entry_total;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] expiry;
      logic [15:0] handle;
      logic        active;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } mem_req_type;

   // The reported total carries the low six bits of the count.
   function automatic logic [5:0] total_of(input logic [CNT_W-1:0] cnt);
      logic [CNT_W+5:0] wide;
      wide = {6'd0, cnt};
      return wide[5:0];
   endfunction

endpackage

// ===== rtl/mhtq_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// Depends on nothing.
module mhtq_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 49,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mhtq_engine.sv =====
// Heap sequencer of the timer queue: add with sift-up, cancel scan, tick with pop and sift-down.
// Depends on mhtq_pkg; drives the entry RAM through one request struct.
module mhtq_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mhtq_pkg::req_type   req_data,
   output mhtq_pkg::mem_req_type mem_req,
   input  mhtq_pkg::entry_type rd_entry,
   output logic                emit_valid,
   input  logic                emit_ready,
   output mhtq_pkg::rsp_type   emit_data
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EMIT     = 4'd1;
   localparam logic [3:0] S_ADD_CHK  = 4'd2;
   localparam logic [3:0] S_ADD_CMP  = 4'd3;
   localparam logic [3:0] S_CAN_RD   = 4'd4;
   localparam logic [3:0] S_CAN_CMP  = 4'd5;
   localparam logic [3:0] S_TK_CHK   = 4'd6;
   localparam logic [3:0] S_TK_CMP   = 4'd7;
   localparam logic [3:0] S_POP      = 4'd8;
   localparam logic [3:0] S_POP_LAST = 4'd9;
   localparam logic [3:0] S_SD_CHK   = 4'd10;
   localparam logic [3:0] S_SD_L     = 4'd11;
   localparam logic [3:0] S_SD_R     = 4'd12;
   localparam logic [3:0] S_SD_DEC   = 4'd13;

   localparam int IW = mhtq_pkg::IDX_W;
   localparam int CW = mhtq_pkg::CNT_W;

   logic [3:0]           state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0]        cnt_ff, cnt_in, scan_ff, scan_in;
   logic [IW-1:0]        pos_ff, pos_in, cidx_ff, cidx_in;
   mhtq_pkg::entry_type  ent_ff, ent_in, child_ff, child_in;
   logic                 found_ff, found_in, pend_ff, pend_in;
   logic [15:0]          pend_h_ff, pend_h_in, pop_h_ff, pop_h_in, hnd_ff, hnd_in;
   logic                 pend_a_ff, pend_a_in, pop_a_ff, pop_a_in;
   logic [31:0]          now_ff, now_in;
   mhtq_pkg::rsp_type    res_ff, res_in;

   logic [CW:0]          cnt_x, lchild_x, rchild_x;
   logic [CW-1:0]        cnt_dec;

   assign cnt_x    = {1'b0, cnt_ff};
   assign lchild_x = (CW + 1)'({pos_ff, 1'b1});
   assign rchild_x = (CW + 1)'(cidx_ff) + (CW + 1)'(1);
   assign cnt_dec  = cnt_ff - CW'(1);

   assign req_ready  = (state_ff == S_IDLE);
   assign emit_valid = (state_ff == S_EMIT);
   assign emit_data  = res_ff;

   always_comb begin
      mhtq_pkg::rsp_type r;
      state_in = state_ff;  ret_in = ret_ff;  cnt_in = cnt_ff;  scan_in = scan_ff;
      pos_in = pos_ff;  cidx_in = cidx_ff;  ent_in = ent_ff;  child_in = child_ff;
      found_in = found_ff;  pend_in = pend_ff;  pend_h_in = pend_h_ff;
      pend_a_in = pend_a_ff;  pop_h_in = pop_h_ff;  pop_a_in = pop_a_ff;
      hnd_in = hnd_ff;  now_in = now_ff;  res_in = res_ff;
      mem_req = '0;
      r = '0;
      r.status = mhtq_pkg::STATUS_OK;
      r.entry_total = mhtq_pkg::total_of(cnt_ff);
      r.last = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.kind)
                  mhtq_pkg::KIND_ADD: begin
                     if (cnt_ff >= CW'(mhtq_pkg::CAPACITY)) begin
                        r.status = mhtq_pkg::STATUS_FULL;
                        res_in = r;  ret_in = S_IDLE;  state_in = S_EMIT;
                     end else begin
                        pos_in = cnt_ff[IW-1:0];
                        cnt_in = cnt_ff + CW'(1);
                        ent_in = '{expiry: req_data.expire_time,
                                   handle: req_data.handle, active: 1'b1};
                        state_in = S_ADD_CHK;
                     end
                  end
                  mhtq_pkg::KIND_CANCEL: begin
                     scan_in = '0;  found_in = 1'b0;  hnd_in = req_data.handle;
                     state_in = S_CAN_RD;
                  end
                  mhtq_pkg::KIND_TICK: begin
                     now_in = req_data.now_time;  pend_in = 1'b0;
                     state_in = S_TK_CHK;
                  end
                  default: begin
                     res_in = r;  ret_in = S_IDLE;  state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (emit_ready) begin
               state_in = ret_ff;
            end
         end
         S_ADD_CHK: begin
            if (pos_ff == '0) begin
               mem_req.wr_en = 1'b1;  mem_req.wr_addr = pos_ff;  mem_req.wr_data = ent_ff;
               res_in = r;  ret_in = S_IDLE;  state_in = S_EMIT;
            end else begin
               cidx_in = IW'((pos_ff - IW'(1)) >> 1);
               mem_req.rd_en = 1'b1;  mem_req.rd_addr = IW'((pos_ff - IW'(1)) >> 1);
               state_in = S_ADD_CMP;
            end
         end
         S_ADD_CMP: begin
            mem_req.wr_en = 1'b1;  mem_req.wr_addr = pos_ff;
            if (rd_entry.expiry <= ent_ff.expiry) begin
               mem_req.wr_data = ent_ff;
               res_in = r;  ret_in = S_IDLE;  state_in = S_EMIT;
            end else begin
               mem_req.wr_data = rd_entry;
               pos_in = cidx_ff;  state_in = S_ADD_CHK;
            end
         end
         S_CAN_RD: begin
            if (scan_ff >= cnt_ff) begin
               r.status = found_ff ? mhtq_pkg::STATUS_OK : mhtq_pkg::STATUS_NOT_FOUND;
               res_in = r;  ret_in = S_IDLE;  state_in = S_EMIT;
            end else begin
               mem_req.rd_en = 1'b1;  mem_req.rd_addr = scan_ff[IW-1:0];
               state_in = S_CAN_CMP;
            end
         end
         S_CAN_CMP: begin
            if (rd_entry.handle == hnd_ff) begin
               mem_req.wr_en = 1'b1;  mem_req.wr_addr = scan_ff[IW-1:0];
               mem_req.wr_data = '{expiry: rd_entry.expiry, handle: rd_entry.handle,
                                   active: 1'b0};
               found_in = 1'b1;
            end
            scan_in = scan_ff + CW'(1);
            state_in = S_CAN_RD;
         end
         S_TK_CHK: begin
            if (cnt_ff == '0) begin
               r.popped_valid = pend_ff;  r.handle_out = pend_ff ? pend_h_ff : 16'd0;
               r.callback_due = pend_ff & pend_a_ff;
               res_in = r;  ret_in = S_IDLE;  state_in = S_EMIT;
            end else begin
               mem_req.rd_en = 1'b1;  mem_req.rd_addr = '0;
               state_in = S_TK_CMP;
            end
         end
         S_TK_CMP: begin
            r.popped_valid = pend_ff;  r.handle_out = pend_ff ? pend_h_ff : 16'd0;
            r.callback_due = pend_ff & pend_a_ff;
            if (rd_entry.expiry <= now_ff) begin
               pop_h_in = rd_entry.handle;  pop_a_in = rd_entry.active;
               if (pend_ff) begin
                  r.last = 1'b0;
                  res_in = r;  ret_in = S_POP;  state_in = S_EMIT;
               end else begin
                  state_in = S_POP;
               end
            end else begin
               res_in = r;  ret_in = S_IDLE;  state_in = S_EMIT;
            end
         end
         S_POP: begin
            pend_in = 1'b1;  pend_h_in = pop_h_ff;  pend_a_in = pop_a_ff;
            cnt_in = cnt_dec;
            if (cnt_dec != '0) begin
               mem_req.rd_en = 1'b1;  mem_req.rd_addr = cnt_dec[IW-1:0];
               state_in = S_POP_LAST;
            end else begin
               state_in = S_TK_CHK;
            end
         end
         S_POP_LAST: begin
            ent_in = rd_entry;  pos_in = '0;  state_in = S_SD_CHK;
         end
         S_SD_CHK: begin
            if (lchild_x >= cnt_x) begin
               mem_req.wr_en = 1'b1;  mem_req.wr_addr = pos_ff;  mem_req.wr_data = ent_ff;
               state_in = S_TK_CHK;
            end else begin
               cidx_in = lchild_x[IW-1:0];
               mem_req.rd_en = 1'b1;  mem_req.rd_addr = lchild_x[IW-1:0];
               state_in = S_SD_L;
            end
         end
         S_SD_L: begin
            child_in = rd_entry;
            if (rchild_x < cnt_x) begin
               mem_req.rd_en = 1'b1;  mem_req.rd_addr = rchild_x[IW-1:0];
               state_in = S_SD_R;
            end else begin
               state_in = S_SD_DEC;
            end
         end
         S_SD_R: begin
            if (rd_entry.expiry < child_ff.expiry) begin
               child_in = rd_entry;  cidx_in = rchild_x[IW-1:0];
            end
            state_in = S_SD_DEC;
         end
         S_SD_DEC: begin
            mem_req.wr_en = 1'b1;  mem_req.wr_addr = pos_ff;
            if (child_ff.expiry < ent_ff.expiry) begin
               mem_req.wr_data = child_ff;
               pos_in = cidx_ff;  state_in = S_SD_CHK;
            end else begin
               mem_req.wr_data = ent_ff;
               state_in = S_TK_CHK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
      scan_ff   <= scan_in;
      pos_ff    <= pos_in;
      cidx_ff   <= cidx_in;
      ent_ff    <= ent_in;
      child_ff  <= child_in;
      pend_h_ff <= pend_h_in;
      pend_a_ff <= pend_a_in;
      pop_h_ff  <= pop_h_in;
      pop_a_ff  <= pop_a_in;
      hnd_ff    <= hnd_in;
      now_ff    <= now_in;
      res_ff    <= res_in;
   end

endmodule

// ===== rtl/min_heap_timer_queue_core.sv =====
// Top level of the timer queue: heap sequencer, entry RAM and the result register.
// Depends on mhtq_pkg, mhtq_ram and mhtq_engine.
//
// A timer queue kept as a binary min-heap of up to CAPACITY entries, each an expiry, a handle
// and an active mark, all held in one synchronous RAM with a registered read. One request is
// worked on at a time. An add sifts the new entry up, one RAM read and one write per heap
// level; a full heap rejects it at once. A cancel reads every held entry in turn and rewrites
// each one whose handle matches, clearing its active mark. A tick pops every entry due at the
// given time; a pop that leaves entries moves the last one to the root and sifts it down,
// reading the left and right child one after the other through the single read port. Every
// access of the RAM is issued in a cycle of its own, after the previous write has landed, so
// no forwarding is needed. Each result transfer goes through an output register, so the next
// request may be taken while the last result of the previous one still waits. A tick result
// is held back until the next root has been compared, so that the final one can carry the
// last flag. Nothing in the RAM needs clearing after reset: only entries below the count are
// ever read.
module min_heap_timer_queue_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mhtq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mhtq_pkg::rsp_type rsp_data
);

   mhtq_pkg::mem_req_type mem_req;
   mhtq_pkg::entry_type   rd_entry;
   logic                  emit_valid, emit_ready;
   mhtq_pkg::rsp_type     emit_data;
   logic                  rsp_valid_ff, rsp_valid_in;
   mhtq_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   mhtq_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .mem_req    (mem_req),
      .rd_entry   (rd_entry),
      .emit_valid (emit_valid),
      .emit_ready (emit_ready),
      .emit_data  (emit_data)
   );

   mhtq_ram #(
      .DEPTH  (mhtq_pkg::CAPACITY),
      .WIDTH  (mhtq_pkg::ENTRY_W),
      .ADDR_W (mhtq_pkg::IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_entry)
   );

   // The result register takes a new result when it is empty or being emptied this cycle.
   assign emit_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_ready) begin
         rsp_valid_in = emit_valid;
         rsp_data_in  = emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/mhtq_checker.sv =====
// Port-level checks of the timer queue and the bind that attaches them to the top level.
// Depends on mhtq_pkg and min_heap_timer_queue_core_defines.svh.
`include "min_heap_timer_queue_core_defines.svh"

module mhtq_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mhtq_pkg::rsp_type rsp_data
);

   `MHTQ_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `MHTQ_ASSERT_NOW(a_full_single, rsp_valid && rsp_data.status == mhtq_pkg::STATUS_FULL, rsp_data.last && !rsp_data.popped_valid, "rejected add must be a lone result")
   `MHTQ_ASSERT_NOW(a_pop_ok, rsp_valid && rsp_data.popped_valid, rsp_data.status == mhtq_pkg::STATUS_OK, "popped entry with bad status")
   `MHTQ_ASSERT_NOW(a_plain_last, rsp_valid && !rsp_data.popped_valid, rsp_data.last && !rsp_data.callback_due, "non-pop result must be final")

endmodule

bind min_heap_timer_queue_core mhtq_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
